// ===== rtl/packet_deframe_crc_check_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer with CRC-32 check
// Each macro expands to one labeled concurrent assertion that is clocked on clk
// and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAME_CRC_CHECK_UNIT_MACROS_SVH
`define PACKET_DEFRAME_CRC_CHECK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDCC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet deframer package
// Shared sizes, register indexes, status codes, types and the CRC-32 byte step.
// ----------------------------------------------------------------------------
package pdcc_pkg;

	localparam int MAX_PACKET_BYTES = 1024;
	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
	localparam int PCOUNT_W = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [7:0] WINDOW_MASK = 8'b0001_1111;

	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd512;
	localparam logic [7:0] TYPE_MASK_RESET = 8'd14;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPTED_TYPE_MASK = 1'd1;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_INCONSISTENT = 3'd1,
		ST_NO_HEADER    = 3'd2,
		ST_CRC          = 3'd3,
		ST_TYPE         = 3'd4,
		ST_LENGTH       = 3'd5,
		ST_NO_PAYLOAD   = 3'd6
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [15:0] max_payload_length;
		logic [7:0]  accepted_type_mask;
	} cfg_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} in_stage_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/pdcc_byte_if.sv =====
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel that carries one received packet byte per item.
// ----------------------------------------------------------------------------
interface pdcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

// ===== rtl/pdcc_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries a payload byte or an end-of-packet status.
// ----------------------------------------------------------------------------
interface pdcc_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [2:0]  status;
	logic [2:0]  header_type;
	logic [4:0]  header_window;
	logic [7:0]  header_seqnum;
	logic [15:0] header_length;
	logic [9:0]  payload_count;

	modport source (
		output valid, output result_kind, output payload_byte, output status,
		output header_type, output header_window, output header_seqnum,
		output header_length, output payload_count, input ready
	);
	modport sink (
		input valid, input result_kind, input payload_byte, input status,
		input header_type, input header_window, input header_seqnum,
		input header_length, input payload_count, output ready
	);
endinterface

// ===== rtl/pdcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the payload length limit and the accepted type mask.
// ----------------------------------------------------------------------------
module pdcc_cfg_regs
	import pdcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_length <= MAX_PAYLOAD_RESET;
			cfg_q.accepted_type_mask <= TYPE_MASK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PAYLOAD_LENGTH: cfg_q.max_payload_length <= cfg_wdata[15:0];
				REG_ACCEPTED_TYPE_MASK: cfg_q.accepted_type_mask <= cfg_wdata[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/pdcc_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one byte item and holds it until the deframer takes it.
// ----------------------------------------------------------------------------
module pdcc_in_stage
	import pdcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pdcc_byte_if.sink   rx,
	input  logic        advance,
	output in_stage_t   stage
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     take;

	assign rx.ready = !valid_s1 || advance;
	assign take = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.byte_value <= rx.byte_value;
			item_s1.last_byte <= rx.last_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item = item_s1;

endmodule

// ===== rtl/pdcc_deframe.sv =====
// ----------------------------------------------------------------------------
// Deframer core
// Tracks the packet position, header fields, tail delay line and running
// CRC-32, and loads the result register with payload bytes and the status.
// ----------------------------------------------------------------------------
module pdcc_deframe
	import pdcc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  in_stage_t     stage,
	output logic          advance,
	pdcc_result_if.source res
);

	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      crc_q;
	logic [7:0]       tail_q [4];
	logic [2:0]       type_q;
	logic [4:0]       window_q;
	logic [7:0]       seqnum_q;
	logic [15:0]      length_q;

	logic [2:0]       type_n;
	logic [4:0]       window_n;
	logic [7:0]       seqnum_n;
	logic [15:0]      length_n;
	logic [7:0]       b;
	logic             in_window;
	logic             emit;
	logic [31:0]      crc_upd;
	logic [31:0]      recv;
	status_t          status_n;
	logic [CNT_W-1:0] emitted;
	logic [CNT_W+PCOUNT_W-1:0] emitted_ext;
	logic             produce;

	logic        valid_s2;
	logic        kind_s2;
	logic [7:0]  payload_s2;
	logic [2:0]  status_s2;
	logic [2:0]  type_s2;
	logic [4:0]  window_s2;
	logic [7:0]  seqnum_s2;
	logic [15:0] length_s2;
	logic [9:0]  pcount_s2;

	assign advance = stage.valid && (!valid_s2 || res.ready);
	assign b = stage.item.byte_value;

	always_comb begin
		type_n = type_q;
		window_n = window_q;
		seqnum_n = seqnum_q;
		length_n = length_q;
		if (cnt_q == CNT_W'(0)) begin
			type_n = b[7:5];
			window_n = 5'(b & WINDOW_MASK);
		end else if (cnt_q == CNT_W'(1)) begin
			seqnum_n = b;
		end else if (cnt_q == CNT_W'(2)) begin
			length_n = {b, length_q[7:0]};
		end else if (cnt_q == CNT_W'(3)) begin
			length_n = {length_q[15:8], b};
		end

		in_window = (cnt_q >= CNT_W'(3)) && (cnt_q < CNT_W'(MAX_PACKET_BYTES));
		emit = in_window && (cnt_q >= CNT_W'(7));
		crc_upd = crc32_byte(crc_q, tail_q[2]);
		recv = {tail_q[2], tail_q[1], tail_q[0], b};

		if (cnt_q >= CNT_W'(8)) begin
			emitted = (cnt_q > CNT_W'(MAX_PACKET_BYTES)) ? CNT_W'(MAX_PACKET_BYTES - 7)
				: cnt_q - CNT_W'(7);
		end else begin
			emitted = '0;
		end
		emitted_ext = {{PCOUNT_W{1'b0}}, emitted};

		if ((cnt_q < CNT_W'(3)) || (cnt_q >= CNT_W'(MAX_PACKET_BYTES))) begin
			status_n = ST_INCONSISTENT;
		end else if (cnt_q < CNT_W'(7)) begin
			status_n = ST_NO_HEADER;
		end else if (recv != ~crc_q) begin
			status_n = ST_CRC;
		end else if (!cfg.accepted_type_mask[type_n]) begin
			status_n = ST_TYPE;
		end else if (length_n > cfg.max_payload_length) begin
			status_n = ST_LENGTH;
		end else if (cnt_q == CNT_W'(7)) begin
			status_n = ST_NO_PAYLOAD;
		end else begin
			status_n = ST_OK;
		end

		produce = stage.item.last_byte || emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= CRC_INIT;
			tail_q <= '{default: 8'd0};
			type_q <= '0;
			window_q <= '0;
			seqnum_q <= '0;
			length_q <= '0;
		end else if (advance) begin
			if (stage.item.last_byte) begin
				cnt_q <= '0;
				crc_q <= CRC_INIT;
				tail_q <= '{default: 8'd0};
				type_q <= '0;
				window_q <= '0;
				seqnum_q <= '0;
				length_q <= '0;
			end else begin
				type_q <= type_n;
				window_q <= window_n;
				seqnum_q <= seqnum_n;
				length_q <= length_n;
				if (in_window) begin
					crc_q <= crc_upd;
				end
				tail_q[3] <= tail_q[2];
				tail_q[2] <= tail_q[1];
				tail_q[1] <= tail_q[0];
				tail_q[0] <= b;
				if (cnt_q <= CNT_W'(MAX_PACKET_BYTES)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && produce) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			if (stage.item.last_byte) begin
				kind_s2 <= KIND_STATUS;
				payload_s2 <= '0;
				status_s2 <= status_n;
				type_s2 <= type_n;
				window_s2 <= window_n;
				seqnum_s2 <= seqnum_n;
				length_s2 <= length_n;
				pcount_s2 <= emitted_ext[PCOUNT_W-1:0];
			end else begin
				kind_s2 <= KIND_PAYLOAD;
				payload_s2 <= tail_q[2];
				status_s2 <= ST_OK;
				type_s2 <= '0;
				window_s2 <= '0;
				seqnum_s2 <= '0;
				length_s2 <= '0;
				pcount_s2 <= '0;
			end
		end
	end

	assign res.valid = valid_s2;
	assign res.result_kind = kind_s2;
	assign res.payload_byte = payload_s2;
	assign res.status = status_s2;
	assign res.header_type = type_s2;
	assign res.header_window = window_s2;
	assign res.header_seqnum = seqnum_s2;
	assign res.header_length = length_s2;
	assign res.payload_count = pcount_s2;

endmodule

// ===== rtl/packet_deframe_crc_check_unit.sv =====
// ----------------------------------------------------------------------------
// Packet deframer with CRC-32 check
// Channels:
//   name  direction  item
//   rx    in         byte_value, last_byte
//   res   out        result_kind, payload_byte, status, header fields, count
// One byte item is taken per cycle while the result register is not stalled;
// each item is held in the input register and its result, if any, is then
// loaded into the result register. The byte-wide CRC-32 step sits between them.
// A stalled result holds the result register; one more item then waits in the
// input register, and rx.ready drops until the result is taken.
// Reset clears the packet state; the configuration returns to its reset values.
// ----------------------------------------------------------------------------
`include "packet_deframe_crc_check_unit_macros.svh"

module packet_deframe_crc_check_unit
	import pdcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pdcc_byte_if.sink             rx,
	pdcc_result_if.source         res
);

	cfg_t      cfg;
	in_stage_t stage;
	logic      advance;

	pdcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pdcc_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.stage   (stage)
	);

	pdcc_deframe u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.stage   (stage),
		.advance (advance),
		.res     (res)
	);

	`PDCC_ASSERT_SAME(a_ready_when_out_free, !res.valid, rx.ready, "input stalled with free result register")
	`PDCC_ASSERT_SAME(a_payload_clean, res.valid && res.result_kind == KIND_PAYLOAD, res.status == ST_OK && res.header_length == 16'd0 && res.payload_count == 10'd0, "payload result carries status fields")
	`PDCC_ASSERT_SAME(a_short_count, res.valid && res.result_kind == KIND_STATUS && (res.status == ST_NO_HEADER || res.status == ST_NO_PAYLOAD), res.payload_count == 10'd0, "short packet reports payload bytes")
	`PDCC_ASSERT_NEXT(a_result_follows, advance && stage.item.last_byte, res.valid && res.result_kind == KIND_STATUS, "last byte gave no status")

endmodule
